FILE: rtl/core/pulse_width_frame_encoder_assert.svh
// Assertion macros shared by the encoder RTL
`ifndef PULSE_WIDTH_FRAME_ENCODER_ASSERT_SVH
`define PULSE_WIDTH_FRAME_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a condition in the same cycle as its trigger
`define PWFE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse_width_frame_encoder: check failed");
// Check a condition in the cycle after its trigger
`define PWFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse_width_frame_encoder: check failed");
`else
`define PWFE_ASSERT_SAME(label, clk, rst, ante, cons)
`define PWFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/pwfe_pkg.sv
package pwfe_pkg;

  // Frame storage
  localparam int MAX_FRAME_BYTES = 4;
  localparam int FRAME_BYTES     = 4;

  // Phase codes
  localparam logic [1:0] PH_PRE_LOW  = 2'd0;
  localparam logic [1:0] PH_PRE_HIGH = 2'd1;
  localparam logic [1:0] PH_DATA     = 2'd2;
  localparam logic [1:0] PH_DONE     = 2'd3;

  // Frame select codes
  localparam logic [1:0] SEL_KEEP   = 2'd0;
  localparam logic [1:0] SEL_FIRST  = 2'd1;
  localparam logic [1:0] SEL_SECOND = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_OPEN_FRAME     = 2'd0;
  localparam logic [1:0] CFG_CLOSE_FRAME    = 2'd1;
  localparam logic [1:0] CFG_UNIT_TICKS     = 2'd2;
  localparam logic [1:0] CFG_PREAMBLE_UNITS = 2'd3;

  // Configuration reset values
  localparam logic [31:0] OPEN_FRAME_RST     = 32'd738241158;
  localparam logic [31:0] CLOSE_FRAME_RST    = 32'd3540014470;
  localparam logic [7:0]  UNIT_TICKS_RST     = 8'd10;
  localparam logic [7:0]  PREAMBLE_UNITS_RST = 8'd60;

  typedef struct packed {
    logic       line_level;
    logic [1:0] phase;
  } result_t;

endpackage

FILE: rtl/core/pwfe_tick_if.sv
interface pwfe_tick_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_select;
  logic [2:0] frame_len;

  modport source (output valid, output frame_select, output frame_len, input ready);
  modport sink   (input valid, input frame_select, input frame_len, output ready);
endinterface

FILE: rtl/core/pwfe_sample_if.sv
interface pwfe_sample_if;
  logic       valid;
  logic       ready;
  logic       line_level;
  logic [1:0] phase;

  modport source (output valid, output line_level, output phase, input ready);
  modport sink   (input valid, input line_level, input phase, output ready);
endinterface

FILE: rtl/core/pulse_width_frame_encoder.sv
// An accepted tick beat's result is registered in the output register, or in the skid register if that one is full.
// Throughput: one tick per cycle while ready is high; next state is one pass of logic from the state registers.
// A two-entry output stage (output register plus skid register) keeps ticks flowing while a
// result waits; ready drops only when both entries are full.
// Reset (rst, synchronous, active high) restores the configuration defaults, returns the
// encoder to the low preamble and empties the output stage.
`include "pulse_width_frame_encoder_assert.svh"

module pulse_width_frame_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  pwfe_tick_if.sink           tick,
  pwfe_sample_if.source       sample
);
  import pwfe_pkg::*;

  // Configuration registers
  logic [31:0] open_frame;
  logic [31:0] close_frame;
  logic [7:0]  unit_ticks;
  logic [7:0]  preamble_units;

  // Encoder state
  logic [1:0]  phase_reg, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [2:0]  byte_index, byte_index_next;
  logic        frame_choice, frame_choice_next;
  logic        line_reg, line_reg_next;

  // Output stage
  logic        out_valid;
  logic        skid_valid;
  result_t     out_data;
  result_t     skid_data;
  result_t     result_next;

  logic        push;
  logic        pop;

  logic [15:0] pre_limit;
  logic [15:0] tick_inc;
  logic [2:0]  len_clamped;
  logic [31:0] frame_sel;
  logic        data_bit;
  logic [8:0]  low_len;
  logic [9:0]  bit_end;

  assign push = tick.valid && tick.ready;
  assign pop  = out_valid && sample.ready;

  // Derived timing values
  assign pre_limit   = {8'd0, unit_ticks} * {8'd0, preamble_units};
  assign tick_inc    = tick_count + 16'd1;
  assign len_clamped = (tick.frame_len > 3'(MAX_FRAME_BYTES)) ? 3'(MAX_FRAME_BYTES)
                                                              : tick.frame_len;
  assign bit_end     = {1'b0, unit_ticks, 1'b0} + {2'b00, unit_ticks};

  // Pick the frame after this beat's select, then the bit under the cursor
  always_comb begin
    frame_choice_next = frame_choice;
    if (tick.frame_select == SEL_FIRST) begin
      frame_choice_next = 1'b0;
    end else if (tick.frame_select == SEL_SECOND) begin
      frame_choice_next = 1'b1;
    end
  end

  assign frame_sel = frame_choice_next ? close_frame : open_frame;
  assign data_bit  = (byte_index < 3'(FRAME_BYTES)) && frame_sel[{byte_index[1:0], bit_index}];
  assign low_len   = data_bit ? {1'b0, unit_ticks} : {unit_ticks, 1'b0};

  // Advance the encoder by one tick
  always_comb begin
    phase_next      = phase_reg;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    byte_index_next = byte_index;
    line_reg_next   = line_reg;
    case (phase_reg)
      PH_PRE_LOW: begin
        line_reg_next   = 1'b0;
        tick_count_next = tick_inc;
        if (tick_inc > pre_limit) begin
          tick_count_next = '0;
          phase_next      = PH_PRE_HIGH;
        end
      end
      PH_PRE_HIGH: begin
        line_reg_next   = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc > {8'd0, unit_ticks}) begin
          tick_count_next = '0;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        tick_count_next = tick_inc;
        if (tick_inc < {7'd0, low_len}) begin
          line_reg_next = 1'b0;
        end else if (tick_inc < {6'd0, bit_end}) begin
          line_reg_next = 1'b1;
        end else begin
          // last tick of the bit: hold the line, step the cursor
          tick_count_next = '0;
          bit_index_next  = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            byte_index_next = byte_index + 3'd1;
          end
        end
        if (byte_index_next >= len_clamped) begin
          tick_count_next = '0;
          byte_index_next = '0;
          bit_index_next  = '0;
          phase_next      = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    result_next.line_level = line_reg_next;
    result_next.phase      = phase_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      open_frame     <= OPEN_FRAME_RST;
      close_frame    <= CLOSE_FRAME_RST;
      unit_ticks     <= UNIT_TICKS_RST;
      preamble_units <= PREAMBLE_UNITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPEN_FRAME:     open_frame     <= cfg_data;
        CFG_CLOSE_FRAME:    close_frame    <= cfg_data;
        CFG_UNIT_TICKS:     unit_ticks     <= cfg_data[7:0];
        CFG_PREAMBLE_UNITS: preamble_units <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Update the encoder state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= PH_PRE_LOW;
      tick_count   <= '0;
      bit_index    <= '0;
      byte_index   <= '0;
      frame_choice <= 1'b0;
      line_reg     <= 1'b0;
    end else if (push) begin
      phase_reg    <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      frame_choice <= frame_choice_next;
      line_reg     <= line_reg_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push && (!out_valid || pop)) begin
      out_data  <= result_next;
      out_valid <= 1'b1;
    end else if (push) begin
      skid_data  <= result_next;
      skid_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign tick.ready        = !skid_valid;
  assign sample.valid      = out_valid;
  assign sample.line_level = out_data.line_level;
  assign sample.phase      = out_data.phase;

  // Checks
  `PWFE_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `PWFE_ASSERT_NEXT(a_done_sticks, clk, rst, phase_reg == PH_DONE, phase_reg == PH_DONE)
  `PWFE_ASSERT_SAME(a_cursor_idle, clk, rst, phase_reg != PH_DATA, {bit_index, byte_index} == 6'd0)
  `PWFE_ASSERT_SAME(a_preamble_low, clk, rst, phase_reg == PH_PRE_LOW, !line_reg)
  `PWFE_ASSERT_NEXT(a_skid_fill, clk, rst, push && out_valid && !pop, skid_valid)

endmodule
